@@ hdl/ffa_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffa_pkg
// Shared types, widths and codes of the first-fit heap allocator.
// ----------------------------------------------------------------------------
package ffa_pkg;

  localparam int unsigned AddrBits   = 20;
  localparam int unsigned SizeBits   = AddrBits + 1;
  localparam int unsigned AlignBits  = 13;
  localparam int unsigned FreeSlots  = 32;
  localparam int unsigned UsedSlots  = 32;

  localparam logic [SizeBits-1:0] HeapMax = SizeBits'(1) << AddrBits;

  localparam logic [1:0] StOk      = 2'd0;
  localparam logic [1:0] StNoSpace = 2'd1;
  localparam logic [1:0] StNoAddr  = 2'd2;
  localparam logic [1:0] StFull    = 2'd3;

  localparam logic ModeAlloc = 1'b0;
  localparam logic ModeFree  = 1'b1;

  typedef struct packed {
    logic                 mode;
    logic [SizeBits-1:0]  alloc_size;
    logic [AlignBits-1:0] alignment;
    logic [AddrBits-1:0]  address;
  } in_item_t;

  typedef struct packed {
    logic [1:0]          status;
    logic [AddrBits-1:0] result_address;
    logic [SizeBits-1:0] largest_free;
  } out_item_t;

  // one descriptor: base address and byte count
  typedef struct packed {
    logic [AddrBits-1:0] base;
    logic [SizeBits-1:0] size;
  } entry_t;

endpackage

@@ hdl/ffa_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffa_ram
// Descriptor table: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ffa_ram #(
  parameter int unsigned Depth = 32,
  parameter int unsigned Width = 41,
  parameter int unsigned IdxW  = 5
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [IdxW-1:0]  waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [IdxW-1:0]  raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ hdl/ffa_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffa_div
// Restoring remainder unit: base modulo alignment, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module ffa_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [ffa_pkg::AddrBits-1:0]  dividend_i,
  input  logic [ffa_pkg::AlignBits-1:0] divisor_i,
  output logic                          done_o,
  output logic [ffa_pkg::AlignBits-1:0] rem_o
);

  localparam int unsigned CntW = $clog2(ffa_pkg::AddrBits + 1);

  logic [ffa_pkg::AddrBits-1:0]  num_q, num_d;
  logic [ffa_pkg::AlignBits-1:0] den_q, den_d;
  logic [ffa_pkg::AlignBits:0]   rem_q, rem_d;
  logic [CntW-1:0]               cnt_q, cnt_d;
  logic                          busy_q, busy_d;
  logic                          done_q, done_d;
  logic [ffa_pkg::AlignBits:0]   shifted;

  always_comb begin
    num_d   = num_q;
    den_d   = den_q;
    rem_d   = rem_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    shifted = {rem_q[ffa_pkg::AlignBits-1:0], num_q[ffa_pkg::AddrBits-1]};
    if (start_i) begin
      num_d  = dividend_i;
      den_d  = divisor_i;
      rem_d  = '0;
      cnt_d  = CntW'(ffa_pkg::AddrBits);
      busy_d = 1'b1;
    end else if (busy_q) begin
      num_d = {num_q[ffa_pkg::AddrBits-2:0], 1'b0};
      if (shifted >= {1'b0, den_q}) begin
        rem_d = shifted - {1'b0, den_q};
      end else begin
        rem_d = shifted;
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    den_q <= den_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q[ffa_pkg::AlignBits-1:0];

endmodule

@@ hdl/first_fit_heap_allocator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_heap_allocator
// First-fit allocator over an address-ordered free table and a used table.
// ----------------------------------------------------------------------------
// One item at a time. Both tables sit in single-port-read RAMs, and every
// table visit is a read followed by a use of the registered data. An
// allocate runs a fit search over the free entries, a merge pass and a
// rescan when nothing fits, the alignment remainder when the alignment is
// nonzero, a move of the later entries when an entry empties, and a final
// largest-free scan. A free searches and moves used entries, passes and
// shifts free entries, and ends with the same largest-free scan. A heap_size
// write takes effect in the following cycle and needs no clearing pass. The
// next item is taken once the result has moved to the output register.
module first_fit_heap_allocator #(
  parameter int unsigned FREE_SLOTS = ffa_pkg::FreeSlots,
  parameter int unsigned USED_SLOTS = ffa_pkg::UsedSlots
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [ffa_pkg::SizeBits-1:0] cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  ffa_pkg::in_item_t            in_item_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output ffa_pkg::out_item_t           out_item_o
);

  localparam int unsigned FIW = (FREE_SLOTS > 1) ? $clog2(FREE_SLOTS) : 1;
  localparam int unsigned UIW = (USED_SLOTS > 1) ? $clog2(USED_SLOTS) : 1;
  localparam int unsigned FCW = $clog2(FREE_SLOTS + 1);
  localparam int unsigned UCW = $clog2(USED_SLOTS + 1);
  localparam int unsigned EW  = $bits(ffa_pkg::entry_t);
  localparam int unsigned AB  = ffa_pkg::AddrBits;
  localparam int unsigned SB  = ffa_pkg::SizeBits;

  localparam logic [4:0] S_IDLE    = 5'd0;
  localparam logic [4:0] S_A0      = 5'd1;
  localparam logic [4:0] S_FIT_RD  = 5'd2;
  localparam logic [4:0] S_FIT_CHK = 5'd3;
  localparam logic [4:0] S_M_RD0   = 5'd4;
  localparam logic [4:0] S_M_FIRST = 5'd5;
  localparam logic [4:0] S_M_RD    = 5'd6;
  localparam logic [4:0] S_M_CHK   = 5'd7;
  localparam logic [4:0] S_DIV     = 5'd8;
  localparam logic [4:0] S_TAKE    = 5'd9;
  localparam logic [4:0] S_FD_RD   = 5'd10;
  localparam logic [4:0] S_FD_WR   = 5'd11;
  localparam logic [4:0] S_U_APP   = 5'd12;
  localparam logic [4:0] S_U_RD    = 5'd13;
  localparam logic [4:0] S_U_CHK   = 5'd14;
  localparam logic [4:0] S_UD_RD   = 5'd15;
  localparam logic [4:0] S_UD_WR   = 5'd16;
  localparam logic [4:0] S_P_RD    = 5'd17;
  localparam logic [4:0] S_P_CHK   = 5'd18;
  localparam logic [4:0] S_SU_RD   = 5'd19;
  localparam logic [4:0] S_SU_WR   = 5'd20;
  localparam logic [4:0] S_INS     = 5'd21;
  localparam logic [4:0] S_L_RD    = 5'd22;
  localparam logic [4:0] S_L_CHK   = 5'd23;
  localparam logic [4:0] S_DONE    = 5'd24;

  logic [4:0]               state_q;
  ffa_pkg::in_item_t        req_q;
  logic [SB-1:0]            heap_q;
  logic [FCW-1:0]           free_cnt_q, fk_q, mw_q, idx_q, pos_q;
  logic [UCW-1:0]           used_cnt_q, uk_q;
  logic                     fresh_q, fresh_rd_q, merged_q;
  ffa_pkg::entry_t          cur_q;
  logic [SB-1:0]            sz_q, max_q;
  logic [ffa_pkg::AlignBits-1:0] pad_q;
  logic [1:0]               status_q;
  logic [AB-1:0]            res_q;
  logic                     out_valid_q;
  ffa_pkg::out_item_t       out_item_q;

  logic [FCW-1:0]  fk_inc, fk_dec, fr_addr, fw_addr;
  logic [UCW-1:0]  uk_inc, uk_dec, ur_addr, uw_addr;
  logic            fwe, uwe;
  ffa_pkg::entry_t fwdata, uwdata, fram_q, uram_q, frd, urd;
  logic [SB:0]     need;
  logic [SB:0]     cur_end;
  logic            adjacent;
  logic            div_start, div_done;
  logic [ffa_pkg::AlignBits-1:0] div_rem;
  logic [AB-1:0]   take_addr;
  logic [SB:0]     take;
  logic [SB-1:0]   take_size;
  logic [AB-1:0]   take_base;
  logic [SB:0]     take_base_sum;
  logic [SB-1:0]   cfg_heap;

  assign fk_inc = fk_q + 1'b1;
  assign fk_dec = fk_q - 1'b1;
  assign uk_inc = uk_q + 1'b1;
  assign uk_dec = uk_q - 1'b1;

  // entry zero reads as the full heap until it is first written
  assign frd = fresh_rd_q ? '{base: '0, size: heap_q} : fram_q;
  assign urd = uram_q;

  assign need          = {1'b0, req_q.alloc_size} + (SB + 1)'(req_q.alignment);
  assign cur_end       = (SB + 1)'(cur_q.base) + {1'b0, cur_q.size};
  assign adjacent      = (cur_end == (SB + 1)'(frd.base));
  assign take_addr     = AB'((SB + 1)'(cur_q.base) + (SB + 1)'(pad_q));
  assign take          = {1'b0, req_q.alloc_size} + (SB + 1)'(pad_q);
  assign take_size     = cur_q.size - take[SB-1:0];
  assign take_base_sum = (SB + 1)'(cur_q.base) + take;
  assign take_base     = take_base_sum[AB-1:0];
  assign cfg_heap      = (cfg_wdata_i > ffa_pkg::HeapMax) ? ffa_pkg::HeapMax : cfg_wdata_i;

  assign div_start = (state_q == S_FIT_CHK) && ({1'b0, frd.size} >= need) &&
                     (fk_q < free_cnt_q) && (req_q.alignment != '0);

  // table port control
  always_comb begin
    fr_addr = fk_q;
    fwe     = 1'b0;
    fw_addr = fk_q;
    fwdata  = cur_q;
    ur_addr = uk_q;
    uwe     = 1'b0;
    uw_addr = uk_q;
    uwdata  = urd;
    unique case (state_q)
      S_M_RD0: fr_addr = '0;
      S_FD_RD: fr_addr = fk_inc;
      S_SU_RD: fr_addr = fk_dec;
      S_M_RD: begin
        if (fk_q >= free_cnt_q) begin
          fwe     = 1'b1;
          fw_addr = mw_q;
        end
      end
      S_M_CHK: begin
        if (!adjacent) begin
          fwe     = 1'b1;
          fw_addr = mw_q;
        end
      end
      S_TAKE: begin
        if (take_size != '0) begin
          fwe     = 1'b1;
          fw_addr = idx_q;
          fwdata  = '{base: take_base, size: take_size};
        end
      end
      S_FD_WR, S_SU_WR: begin
        fwe    = 1'b1;
        fwdata = frd;
      end
      S_INS: begin
        fwe     = 1'b1;
        fw_addr = pos_q;
        fwdata  = '{base: req_q.address, size: sz_q};
      end
      S_U_RD:  ur_addr = uk_dec;
      S_UD_RD: ur_addr = uk_inc;
      S_UD_WR: uwe = 1'b1;
      S_U_APP: begin
        uwe     = 1'b1;
        uw_addr = used_cnt_q;
        uwdata  = '{base: res_q, size: req_q.alloc_size};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      heap_q      <= ffa_pkg::HeapMax;
      free_cnt_q  <= FCW'(1);
      used_cnt_q  <= '0;
      fresh_q     <= 1'b1;
      fresh_rd_q  <= 1'b0;
      out_valid_q <= 1'b0;
      merged_q    <= 1'b0;
    end else begin
      fresh_rd_q <= fresh_q && (fr_addr == '0);
      if (fwe && (fw_addr == '0)) begin
        fresh_q <= 1'b0;
      end
      if (out_valid_q && !out_stall_i && (state_q != S_DONE)) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        heap_q     <= cfg_heap;
        free_cnt_q <= (cfg_heap == '0) ? '0 : FCW'(1);
        used_cnt_q <= '0;
        fresh_q    <= 1'b1;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            state_q <= (in_item_i.mode == ffa_pkg::ModeAlloc) ? S_A0 : S_U_RD;
            uk_q    <= used_cnt_q;
            res_q   <= '0;
            max_q   <= '0;
          end
        end
        S_A0: begin
          fk_q     <= '0;
          merged_q <= 1'b0;
          if (req_q.alloc_size == '0) begin
            status_q <= ffa_pkg::StNoSpace;
            state_q  <= S_L_RD;
          end else if (used_cnt_q >= UCW'(USED_SLOTS)) begin
            status_q <= ffa_pkg::StFull;
            state_q  <= S_L_RD;
          end else begin
            state_q <= S_FIT_RD;
          end
        end
        S_FIT_RD: begin
          if (fk_q < free_cnt_q) begin
            state_q <= S_FIT_CHK;
          end else if (!merged_q && (free_cnt_q > FCW'(1))) begin
            state_q <= S_M_RD0;
          end else begin
            status_q <= ffa_pkg::StNoSpace;
            fk_q     <= '0;
            state_q  <= S_L_RD;
          end
        end
        S_FIT_CHK: begin
          if ({1'b0, frd.size} >= need) begin
            cur_q <= frd;
            idx_q <= fk_q;
            pad_q <= '0;
            state_q <= (req_q.alignment != '0) ? S_DIV : S_TAKE;
          end else begin
            fk_q    <= fk_inc;
            state_q <= S_FIT_RD;
          end
        end
        S_M_RD0: state_q <= S_M_FIRST;
        S_M_FIRST: begin
          cur_q   <= frd;
          fk_q    <= FCW'(1);
          mw_q    <= '0;
          state_q <= S_M_RD;
        end
        S_M_RD: begin
          if (fk_q >= free_cnt_q) begin
            free_cnt_q <= mw_q + 1'b1;
            merged_q   <= 1'b1;
            fk_q       <= '0;
            state_q    <= S_FIT_RD;
          end else begin
            state_q <= S_M_CHK;
          end
        end
        S_M_CHK: begin
          if (adjacent) begin
            cur_q.size <= cur_q.size + frd.size;
          end else begin
            mw_q  <= mw_q + 1'b1;
            cur_q <= frd;
          end
          fk_q    <= fk_inc;
          state_q <= S_M_RD;
        end
        S_DIV: begin
          if (div_done) begin
            pad_q   <= (div_rem == '0) ? '0 : req_q.alignment - div_rem;
            state_q <= S_TAKE;
          end
        end
        S_TAKE: begin
          res_q <= take_addr;
          fk_q  <= idx_q;
          state_q <= (take_size == '0) ? S_FD_RD : S_U_APP;
        end
        S_FD_RD: begin
          if (fk_inc >= free_cnt_q) begin
            free_cnt_q <= free_cnt_q - 1'b1;
            state_q    <= S_U_APP;
          end else begin
            state_q <= S_FD_WR;
          end
        end
        S_FD_WR: begin
          fk_q    <= fk_inc;
          state_q <= S_FD_RD;
        end
        S_U_APP: begin
          used_cnt_q <= used_cnt_q + 1'b1;
          status_q   <= ffa_pkg::StOk;
          fk_q       <= '0;
          state_q    <= S_L_RD;
        end
        S_U_RD: begin
          fk_q <= '0;
          if (uk_q == '0) begin
            status_q <= ffa_pkg::StNoAddr;
            state_q  <= S_L_RD;
          end else begin
            state_q <= S_U_CHK;
          end
        end
        S_U_CHK: begin
          uk_q <= uk_dec;
          if (urd.base == req_q.address) begin
            sz_q <= urd.size;
            if (free_cnt_q >= FCW'(FREE_SLOTS)) begin
              status_q <= ffa_pkg::StFull;
              state_q  <= S_L_RD;
            end else begin
              state_q <= S_UD_RD;
            end
          end else begin
            state_q <= S_U_RD;
          end
        end
        S_UD_RD: begin
          if (uk_inc >= used_cnt_q) begin
            used_cnt_q <= used_cnt_q - 1'b1;
            state_q    <= S_P_RD;
          end else begin
            state_q <= S_UD_WR;
          end
        end
        S_UD_WR: begin
          uk_q    <= uk_inc;
          state_q <= S_UD_RD;
        end
        S_P_RD: begin
          // scan ran off the end: fk already equals the free count
          if (fk_q >= free_cnt_q) begin
            pos_q   <= fk_q;
            state_q <= S_SU_RD;
          end else begin
            state_q <= S_P_CHK;
          end
        end
        S_P_CHK: begin
          if (frd.base < req_q.address) begin
            fk_q    <= fk_inc;
            state_q <= S_P_RD;
          end else begin
            pos_q   <= fk_q;
            fk_q    <= free_cnt_q;
            state_q <= S_SU_RD;
          end
        end
        S_SU_RD: begin
          state_q <= (fk_q <= pos_q) ? S_INS : S_SU_WR;
        end
        S_SU_WR: begin
          fk_q    <= fk_dec;
          state_q <= S_SU_RD;
        end
        S_INS: begin
          free_cnt_q <= free_cnt_q + 1'b1;
          status_q   <= ffa_pkg::StOk;
          fk_q       <= '0;
          state_q    <= S_L_RD;
        end
        S_L_RD: begin
          state_q <= (fk_q < free_cnt_q) ? S_L_CHK : S_DONE;
        end
        S_L_CHK: begin
          if (frd.size > max_q) begin
            max_q <= frd.size;
          end
          fk_q    <= fk_inc;
          state_q <= S_L_RD;
        end
        S_DONE: begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if ((state_q == S_IDLE) && in_valid_i) begin
      req_q <= in_item_i;
    end
    if ((state_q == S_DONE) && (!out_valid_q || !out_stall_i)) begin
      out_item_q.status         <= status_q;
      out_item_q.result_address <= (status_q == ffa_pkg::StOk) ? res_q : '0;
      out_item_q.largest_free   <= max_q;
    end
  end

  ffa_ram #(
    .Depth (FREE_SLOTS),
    .Width (EW),
    .IdxW  (FIW)
  ) u_free_ram (
    .clk_i   (clk_i),
    .we_i    (fwe),
    .waddr_i (fw_addr[FIW-1:0]),
    .wdata_i (fwdata),
    .raddr_i (fr_addr[FIW-1:0]),
    .rdata_o (fram_q)
  );

  ffa_ram #(
    .Depth (USED_SLOTS),
    .Width (EW),
    .IdxW  (UIW)
  ) u_used_ram (
    .clk_i   (clk_i),
    .we_i    (uwe),
    .waddr_i (uw_addr[UIW-1:0]),
    .wdata_i (uwdata),
    .raddr_i (ur_addr[UIW-1:0]),
    .rdata_o (uram_q)
  );

  ffa_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (frd.base),
    .divisor_i  (req_q.alignment),
    .done_o     (div_done),
    .rem_o      (div_rem)
  );

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

`ifndef ASSERT_OFF
  a_free_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    free_cnt_q <= FCW'(FREE_SLOTS))
    else $error("free table count out of range");

  a_used_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_cnt_q <= UCW'(USED_SLOTS))
    else $error("used table count out of range");

  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_DONE))
    else $error("result raised outside completion");

  a_fail_zero_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_item_q.status != ffa_pkg::StOk)) |->
      (out_item_q.result_address == '0))
    else $error("failed item carries an address");
`endif

endmodule
